FILE: hw/rtl/chunked_bump_allocator_unit_macros.svh
// assertion shorthands for the allocator rtl
`ifndef CHUNKED_BUMP_ALLOCATOR_UNIT_MACROS_SVH
`define CHUNKED_BUMP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication, disabled during reset
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

FILE: hw/rtl/cba_pkg.sv
package cba_pkg;

   // payload field widths
   localparam int REQ_SIZE_W      = 24;
   localparam int CHUNK_INDEX_W   = 6;
   localparam int BYTE_OFFSET_W   = 24;
   localparam int REQ_TDATA_W     = 24;
   localparam int RSP_TDATA_W     = 32;
   localparam int RSP_TUSER_W     = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;

   // register map
   localparam int REG_DEFAULT_CHUNK_SIZE = 0;
   localparam int DEFAULT_CHUNK_RESET    = 4096;

   // sequencer steps
   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_RD_CUR,
      S_CHK_CUR,
      S_SCAN,
      S_BUMP,
      S_NEW
   } step_type;

   // branch conditions
   typedef enum logic [2:0] {
      C_NEVER,
      C_REQ,
      C_FIT,
      C_LAST,
      C_OUT_FREE
   } cond_type;

   // chunk table read address select
   typedef enum logic [1:0] {
      RD_HOLD,
      RD_CUR,
      RD_ZERO,
      RD_NEXT
   } rd_sel_type;

   // datapath action of a step
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_OPEN_FIRST,
      ACT_BUMP,
      ACT_NEW
   } act_type;

   // one control word
   typedef struct packed {
      logic       take;
      logic       latch;
      rd_sel_type rd_sel;
      act_type    act;
      cond_type   cond_a;
      step_type   jmp_a;
      cond_type   cond_b;
      step_type   jmp_b;
      step_type   nxt;
   } ctrl_type;

   // control store
   function automatic ctrl_type ucode(input step_type s);
      ctrl_type c;
      c = '{take: 1'b0, latch: 1'b0, rd_sel: RD_HOLD, act: ACT_NONE,
            cond_a: C_NEVER, jmp_a: S_IDLE, cond_b: C_NEVER, jmp_b: S_IDLE,
            nxt: S_IDLE};
      unique case (s)
         S_IDLE: begin
            c.take   = 1'b1;
            c.cond_a = C_REQ;
            c.jmp_a  = S_FIRST;
            c.nxt    = S_IDLE;
         end
         S_FIRST: begin
            c.act = ACT_OPEN_FIRST;
            c.nxt = S_RD_CUR;
         end
         S_RD_CUR: begin
            c.rd_sel = RD_CUR;
            c.nxt    = S_CHK_CUR;
         end
         S_CHK_CUR: begin
            c.latch  = 1'b1;
            c.rd_sel = RD_ZERO;
            c.cond_a = C_FIT;
            c.jmp_a  = S_BUMP;
            c.nxt    = S_SCAN;
         end
         S_SCAN: begin
            c.latch  = 1'b1;
            c.rd_sel = RD_NEXT;
            c.cond_a = C_FIT;
            c.jmp_a  = S_BUMP;
            c.cond_b = C_LAST;
            c.jmp_b  = S_NEW;
            c.nxt    = S_SCAN;
         end
         S_BUMP: begin
            c.act    = ACT_BUMP;
            c.cond_a = C_OUT_FREE;
            c.jmp_a  = S_IDLE;
            c.nxt    = S_BUMP;
         end
         S_NEW: begin
            c.act    = ACT_NEW;
            c.cond_a = C_OUT_FREE;
            c.jmp_a  = S_IDLE;
            c.nxt    = S_NEW;
         end
         default: begin
            c.nxt = S_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/cba_ram.sv
module cba_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/chunked_bump_allocator_unit.sv
// flow: the request is taken while idle, the first request opens chunk 0, the current chunk
// is read and tested, on a miss a first-fit scan runs from chunk 0, and a full miss opens
// a new chunk; the scan reads one chunk table entry per cycle through the single memory
// read port. A request is taken only while idle; a result may wait while the next is taken.
// reset: sequencer idle, no chunk open, current chunk 0, no result pending, chunk size 4096;
// the chunk table has no clearing pass, an entry is written before it is ever read.
`include "chunked_bump_allocator_unit_macros.svh"

module chunked_bump_allocator_unit #(
   parameter int MAX_CHUNKS = 64,
   parameter int SIZE_BITS  = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cba_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [23:0] req_size
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cba_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [5:0] chunk_index, [29:6] byte_offset
   output logic [cba_pkg::RSP_TUSER_W-1:0]  rsp_tuser,   // [0] granted, [1] opened_chunk
   // configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cba_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cba_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cba_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import cba_pkg::*;

   localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int OPEN_W = $clog2(MAX_CHUNKS + 1);
   localparam int ENT_W  = 2 * SIZE_BITS;

   // sequencer
   step_type pc_ff, pc_in;
   ctrl_type ctrl;

   // architectural state
   logic [SIZE_BITS-1:0] default_ff, default_in;
   logic [OPEN_W-1:0]    open_ff, open_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;

   // working registers
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [SIZE_BITS-1:0] hit_cap_ff, hit_cap_in;
   logic [SIZE_BITS-1:0] hit_fill_ff, hit_fill_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_granted_ff, rsp_granted_in;
   logic                     rsp_opened_ff, rsp_opened_in;
   logic [CHUNK_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [BYTE_OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   // chunk table port
   logic             tbl_wr_en;
   logic [IDX_W-1:0] tbl_wr_addr;
   logic [ENT_W-1:0] tbl_wr_data;
   logic [ENT_W-1:0] tbl_rd_data;
   logic [SIZE_BITS-1:0] rd_cap, rd_fill;

   // decoded conditions and helpers
   logic                 fits, last, out_free, table_full, req_xfer, csr_wr, new_commit;
   logic [OPEN_W-1:0]    rd_idx_ext;
   logic [SIZE_BITS-1:0] new_cap;
   logic [SIZE_BITS+REQ_SIZE_W-1:0]       size_wide;
   logic [SIZE_BITS+BYTE_OFFSET_W-1:0]    off_wide;
   logic [IDX_W+CHUNK_INDEX_W-1:0]        bump_idx_wide, new_idx_wide;
   logic [SIZE_BITS+CSR_DATA_W-1:0]       prdata_wide;

   cba_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_CHUNKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (rd_idx_in),
      .rd_data (tbl_rd_data)
   );

   // control store lookup
   always_comb begin
      ctrl = ucode(pc_ff);
   end

   // datapath conditions
   assign rd_cap     = tbl_rd_data[ENT_W-1:SIZE_BITS];
   assign rd_fill    = tbl_rd_data[SIZE_BITS-1:0];
   assign fits       = (rd_cap - rd_fill) > size_ff;
   assign rd_idx_ext = OPEN_W'(rd_idx_ff);
   assign last       = (rd_idx_ext + 1'b1) == open_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign table_full = open_ff == OPEN_W'(MAX_CHUNKS);
   assign req_xfer   = req_tvalid && req_tready;
   assign new_cap    = (default_ff > size_ff) ? default_ff : size_ff;
   assign new_commit = (pc_ff == S_NEW) && out_free && !table_full;

   function automatic logic cond_true(input cond_type c, input logic f_req,
                                      input logic f_fit, input logic f_last,
                                      input logic f_out);
      logic r;
      unique case (c)
         C_NEVER:    r = 1'b0;
         C_REQ:      r = f_req;
         C_FIT:      r = f_fit;
         C_LAST:     r = f_last;
         C_OUT_FREE: r = f_out;
         default:    r = 1'b0;
      endcase
      return r;
   endfunction

   // next step
   always_comb begin
      priority if (cond_true(ctrl.cond_a, req_tvalid, fits, last, out_free)) begin
         pc_in = ctrl.jmp_a;
      end else if (cond_true(ctrl.cond_b, req_tvalid, fits, last, out_free)) begin
         pc_in = ctrl.jmp_b;
      end else begin
         pc_in = ctrl.nxt;
      end
   end

   // request capture and chunk table read address
   assign req_tready = ctrl.take;
   assign size_wide  = {{SIZE_BITS{1'b0}}, req_tdata[REQ_SIZE_W-1:0]};
   assign size_in    = req_xfer ? size_wide[SIZE_BITS-1:0] : size_ff;

   always_comb begin
      unique case (ctrl.rd_sel)
         RD_HOLD: rd_idx_in = rd_idx_ff;
         RD_CUR:  rd_idx_in = cur_ff;
         RD_ZERO: rd_idx_in = '0;
         RD_NEXT: rd_idx_in = last ? rd_idx_ff : rd_idx_ff + 1'b1;
         default: rd_idx_in = rd_idx_ff;
      endcase
   end

   // hold the entry under test so a hit survives the next read
   assign hit_idx_in  = ctrl.latch ? rd_idx_ff : hit_idx_ff;
   assign hit_cap_in  = ctrl.latch ? rd_cap : hit_cap_ff;
   assign hit_fill_in = ctrl.latch ? rd_fill : hit_fill_ff;

   assign off_wide      = {{BYTE_OFFSET_W{1'b0}}, hit_fill_ff};
   assign bump_idx_wide = {{CHUNK_INDEX_W{1'b0}}, hit_idx_ff};
   assign new_idx_wide  = {{CHUNK_INDEX_W{1'b0}}, open_ff[IDX_W-1:0]};

   // step actions: table writes, state updates, result load
   always_comb begin
      tbl_wr_en      = 1'b0;
      tbl_wr_addr    = hit_idx_ff;
      tbl_wr_data    = {hit_cap_ff, hit_fill_ff + size_ff};
      open_in        = open_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_opened_in  = rsp_opened_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_offset_in  = rsp_offset_ff;
      unique case (ctrl.act)
         ACT_NONE: begin
         end
         ACT_OPEN_FIRST: begin
            if (open_ff == '0) begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = '0;
               tbl_wr_data = {default_ff, {SIZE_BITS{1'b0}}};
               open_in     = OPEN_W'(1);
               cur_in      = '0;
            end
         end
         ACT_BUMP: begin
            if (out_free) begin
               tbl_wr_en      = 1'b1;
               cur_in         = hit_idx_ff;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b1;
               rsp_opened_in  = 1'b0;
               rsp_index_in   = bump_idx_wide[CHUNK_INDEX_W-1:0];
               rsp_offset_in  = off_wide[BYTE_OFFSET_W-1:0];
            end
         end
         ACT_NEW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (table_full) begin
                  rsp_granted_in = 1'b0;
                  rsp_opened_in  = 1'b0;
                  rsp_index_in   = '0;
                  rsp_offset_in  = '0;
               end else begin
                  tbl_wr_en      = 1'b1;
                  tbl_wr_addr    = open_ff[IDX_W-1:0];
                  tbl_wr_data    = {new_cap, size_ff};
                  open_in        = open_ff + 1'b1;
                  cur_in         = open_ff[IDX_W-1:0];
                  rsp_granted_in = 1'b1;
                  rsp_opened_in  = 1'b1;
                  rsp_index_in   = new_idx_wide[CHUNK_INDEX_W-1:0];
                  rsp_offset_in  = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // configuration register
   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                        (csr_paddr[2] == 1'(REG_DEFAULT_CHUNK_SIZE));
   assign default_in  = csr_wr ? csr_pwdata[SIZE_BITS-1:0] : default_ff;
   assign prdata_wide = {{CSR_DATA_W{1'b0}}, default_ff};
   assign csr_prdata  = (csr_paddr[2] == 1'(REG_DEFAULT_CHUNK_SIZE)) ?
                        prdata_wide[CSR_DATA_W-1:0] : '0;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_IDLE;
         open_ff      <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         default_ff   <= SIZE_BITS'(DEFAULT_CHUNK_RESET);
      end else begin
         pc_ff        <= pc_in;
         open_ff      <= open_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         default_ff   <= default_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      size_ff        <= size_in;
      rd_idx_ff      <= rd_idx_in;
      hit_idx_ff     <= hit_idx_in;
      hit_cap_ff     <= hit_cap_in;
      hit_fill_ff    <= hit_fill_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_opened_ff  <= rsp_opened_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_offset_ff  <= rsp_offset_in;
   end

   // result stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - BYTE_OFFSET_W - CHUNK_INDEX_W){1'b0}},
                        rsp_offset_ff, rsp_index_ff};
   assign rsp_tuser  = {rsp_opened_ff, rsp_granted_ff};

   // checks
   `CBA_ASSERT_IMPL(a_cur_below_open, clock, reset, open_ff != '0, OPEN_W'(cur_ff) < open_ff)
   `CBA_ASSERT_IMPL(a_scan_in_range, clock, reset, pc_ff == S_SCAN, rd_idx_ext < open_ff)
   `CBA_ASSERT_NEXT(a_new_opens_one, clock, reset, new_commit, open_ff == $past(open_ff) + 1'b1)

endmodule

FILE: verif/chunked_bump_allocator_unit_test.sv
module chunked_bump_allocator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cba_pkg::*;

   localparam int TABLE_DEPTH    = 64;
   localparam int SIZE_W         = 24;
   localparam int PHASE_ITEMS    = 330;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 80;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [CSR_ADDR_W-1:0] CFG_ADDR   = CSR_ADDR_W'(4 * REG_DEFAULT_CHUNK_SIZE);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4 * (REG_DEFAULT_CHUNK_SIZE + 1));

   // how a queued request size is chosen when it is presented
   typedef enum logic {
      SIZE_FIXED,
      SIZE_NEAR_FREE
   } size_kind_type;

   typedef struct {
      size_kind_type     kind;
      logic [SIZE_W-1:0] value;
   } size_item_type;

   typedef struct packed {
      logic                     granted;
      logic [CHUNK_INDEX_W-1:0] chunk_index;
      logic [BYTE_OFFSET_W-1:0] byte_offset;
      logic                     opened_chunk;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [23:0] req_size
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [5:0] chunk_index, [29:6] byte_offset
   logic [RSP_TUSER_W-1:0] rsp_tuser;         // [0] granted, [1] opened_chunk
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // allocator image kept by the testbench
   logic [SIZE_W-1:0]        chunk_cap  [TABLE_DEPTH] = '{default: '0};
   logic [SIZE_W-1:0]        chunk_used [TABLE_DEPTH] = '{default: '0};
   int                       chunks_live = 0;
   logic [CHUNK_INDEX_W-1:0] cur_chunk   = '0;
   logic [SIZE_W-1:0]        dflt_size   = SIZE_W'(DEFAULT_CHUNK_RESET);

   size_item_type size_q[$];
   grant_type     grant_q[$];
   int            mismatch_cnt = 0;
   int            idle_cycles  = 0;

   int drv_gap   = 0;
   bit drv_busy  = 1'b0;
   bit req_burst = 1'b0;
   int rsp_stall = 0;
   bit rsp_burst = 1'b0;

   chunked_bump_allocator_unit #(
      .MAX_CHUNKS (TABLE_DEPTH),
      .SIZE_BITS  (SIZE_W)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit chunk_has_room(input int k, input logic [SIZE_W-1:0] sz);
      return (chunk_cap[k] - chunk_used[k]) > sz;
   endfunction

   // current chunk first, then first fit from chunk 0, else open a new chunk or refuse when full
   function automatic grant_type alloc_predict(input logic [SIZE_W-1:0] sz);
      grant_type g;
      logic [SIZE_W-1:0] start;
      g = '0;
      // the pool's initial chunk appears with the first request
      if (chunks_live == 0) begin
         chunk_cap[0]  = dflt_size;
         chunk_used[0] = '0;
         chunks_live   = 1;
         cur_chunk     = '0;
      end
      if (int'(cur_chunk) < chunks_live && chunk_has_room(int'(cur_chunk), sz)) begin
         start = chunk_used[cur_chunk];
         chunk_used[cur_chunk] = start + sz;
         g.granted     = 1'b1;
         g.chunk_index = cur_chunk;
         g.byte_offset = start;
         return g;
      end
      for (int k = 0; k < chunks_live; k++) begin
         if (chunk_has_room(k, sz)) begin
            start = chunk_used[k];
            chunk_used[k] = start + sz;
            cur_chunk     = CHUNK_INDEX_W'(k);
            g.granted     = 1'b1;
            g.chunk_index = CHUNK_INDEX_W'(k);
            g.byte_offset = start;
            return g;
         end
      end
      // table full leaves the state alone
      if (chunks_live >= TABLE_DEPTH)
         return g;
      chunk_cap[chunks_live]  = (dflt_size > sz) ? dflt_size : sz;
      chunk_used[chunks_live] = sz;
      cur_chunk      = CHUNK_INDEX_W'(chunks_live);
      g.granted      = 1'b1;
      g.chunk_index  = CHUNK_INDEX_W'(chunks_live);
      g.opened_chunk = 1'b1;
      chunks_live++;
      return g;
   endfunction

   // fixed sizes as given, else sizes around the free space of the current or a random open chunk
   function automatic logic [SIZE_W-1:0] pick_size(input size_item_type it);
      int k;
      logic [SIZE_W-1:0] room;
      if (it.kind == SIZE_FIXED)
         return it.value;
      if (chunks_live == 0) begin
         room = dflt_size;
      end else begin
         k = ($urandom_range(0, 1) == 0) ? int'(cur_chunk)
                                         : $urandom_range(0, chunks_live - 1);
         room = chunk_cap[k] - chunk_used[k];
      end
      return room + it.value - 1'b1;
   endfunction

   // request driver, predicts each transfer as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         drv_gap = 0;
      end else begin
         drv_busy = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            grant_q.push_back(alloc_predict(req_tdata[SIZE_W-1:0]));
            if ($urandom_range(0, 63) == 0)
               req_burst = !req_burst;
         end
         if (!drv_busy) begin
            if (drv_gap == 0 && size_q.size() > 0) begin
               req_tdata  <= pick_size(size_q.pop_front());
               req_tvalid <= 1'b1;
               drv_gap = req_burst ? 0 : $urandom_range(0, 6);
            end else begin
               req_tvalid <= 1'b0;
               if (drv_gap > 0)
                  drv_gap--;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      grant_type got;
      grant_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.granted      = rsp_tuser[0];
            got.opened_chunk = rsp_tuser[1];
            got.chunk_index  = rsp_tdata[CHUNK_INDEX_W-1:0];
            got.byte_offset  = rsp_tdata[CHUNK_INDEX_W +: BYTE_OFFSET_W];
            if (grant_q.size() == 0) begin
               if (mismatch_cnt < REPORT_LIMIT)
                  $display("%0t unexpected result: granted %0b index %0d",
                           $realtime, got.granted, got.chunk_index,
                           " offset 0x%06h opened %0b",
                           got.byte_offset, got.opened_chunk);
               mismatch_cnt++;
            end else begin
               want = grant_q.pop_front();
               if (got.granted !== want.granted || got.chunk_index !== want.chunk_index ||
                   got.byte_offset !== want.byte_offset ||
                   got.opened_chunk !== want.opened_chunk) begin
                  if (mismatch_cnt < REPORT_LIMIT)
                     $display("%0t result mismatch: expected granted %0b index %0d",
                              $realtime, want.granted, want.chunk_index,
                              " offset 0x%06h opened %0b,",
                              want.byte_offset, want.opened_chunk,
                              " got granted %0b index %0d offset 0x%06h opened %0b",
                              got.granted, got.chunk_index, got.byte_offset,
                              got.opened_chunk);
                  mismatch_cnt++;
               end
            end
            if ($urandom_range(0, 63) == 0)
               rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 6);
         end else if (rsp_tvalid && rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_size(input logic [SIZE_W-1:0] v);
      size_q.push_back('{SIZE_FIXED, v});
   endtask

   // wait until every request is taken and every result is back
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (size_q.size() != 0 || req_tvalid || grant_q.size() != 0);
   endtask

   // setup and access cycle, written where psel, penable and pready meet
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CFG_ADDR)
         dflt_size = data[SIZE_W-1:0];
      @(negedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] phase_cfg [6];
      logic [CSR_DATA_W-1:0] cfg;
      logic [SIZE_W-1:0]     near_dflt;
      int r;
      phase_cfg = '{32'h0000_1000, 32'h0000_0001, 32'hFFFF_FFFF,
                    32'h0000_0000, 32'hAB00_0000, 32'h0000_0000};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset chunk size: lazy first chunk, exact fit refused, rescans, size extremes
      add_size(24'd0);
      add_size(24'd100);
      add_size(24'd4095);
      add_size(24'd0);
      add_size(24'd3995);
      add_size(24'd0);
      add_size(24'd1);
      add_size(24'hFF_FFFF);
      add_size(24'hFF_FFFE);
      add_size(24'd1);
      wait_quiet();

      // widest chunk size, upper write bits dropped
      csr_write(CFG_ADDR, 32'hFFFF_FFFF);
      add_size(24'd1);
      add_size(24'h7F_FFFF);
      add_size(24'h80_0000);
      wait_quiet();

      // write to an unmapped register must leave the chunk size alone
      csr_write(SPARE_ADDR, 32'h0000_0001);
      add_size(24'hFF_FFF0);
      add_size(24'd1);
      wait_quiet();

      // zero chunk size: new chunks hold exactly the request
      csr_write(CFG_ADDR, 32'hAB00_0000);
      add_size(24'h12_3456);
      add_size(24'd0);
      add_size(24'h5A_5A5A);
      add_size(24'd0);
      wait_quiet();

      // random phases, each under its own chunk size
      for (int p = 0; p < 6; p++) begin
         cfg = phase_cfg[p];
         if (p == 3 || p == 5)
            cfg = $urandom();
         csr_write(CFG_ADDR, cfg);
         near_dflt = cfg[SIZE_W-1:0];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
               add_size(SIZE_W'($urandom_range(0, 512)));
            else if (r < 75)
               size_q.push_back('{SIZE_NEAR_FREE, SIZE_W'($urandom_range(0, 2))});
            else if (r < 85)
               add_size(near_dflt - 1'b1 + SIZE_W'($urandom_range(0, 2)));
            else if (r < 95)
               add_size(SIZE_W'($urandom()));
            else
               add_size(($urandom_range(0, 1) == 0) ? 24'h00_0000 : 24'hFF_FFFF);
         end
         wait_quiet();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && grant_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cba_pkg.sv
hw/rtl/cba_ram.sv
hw/rtl/chunked_bump_allocator_unit.sv
verif/chunked_bump_allocator_unit_test.sv
